// File: design/lrg_pkg.sv
// Shared types and constants for the life row generation step.
// Holds the beat structs, the rule register set and the queue sizing.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package lrg_pkg;

    // Row width limits and default
    localparam int ROW_W        = 64;
    localparam int COLS_DEFAULT = 64;

    // Neighbor counts run 0..8, bounds are 4-bit registers
    localparam int CNT_W = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_MIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_MAX = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIRTH_MIN   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIRTH_MAX   = 8'd3;

    localparam logic [CNT_W-1:0] SURVIVE_MIN_RST = 4'd2;
    localparam logic [CNT_W-1:0] SURVIVE_MAX_RST = 4'd3;
    localparam logic [CNT_W-1:0] BIRTH_MIN_RST   = 4'd3;
    localparam logic [CNT_W-1:0] BIRTH_MAX_RST   = 4'd3;

    // Result queue depth, a power of two
    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic [ROW_W-1:0] row_cells;
        logic             frame_end;
    } row_beat_t;

    typedef struct packed {
        logic [ROW_W-1:0] next_cells;
        logic             final_row;
    } gen_beat_t;

    typedef struct packed {
        logic [CNT_W-1:0] survive_min;
        logic [CNT_W-1:0] survive_max;
        logic [CNT_W-1:0] birth_min;
        logic [CNT_W-1:0] birth_max;
    } rules_t;

    // Per-beat control broadcast along the cell row
    typedef struct packed {
        logic advance;
        logic flush;
    } cell_ctrl_t;

    // Result pushes for one accepted row
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

// File: design/lrg_cell.sv
// One column cell: holds the above and middle bits of its column and
// evaluates the rule for the middle row and for the incoming row.
// Depends on lrg_pkg for the rule and control structs.
`timescale 1ns / 1ps

module lrg_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  lrg_pkg::cell_ctrl_t ctrl,
    input  lrg_pkg::rules_t    rules,
    input  logic               row_l,
    input  logic               row_c,
    input  logic               row_r,
    input  logic               above_l,
    input  logic               above_r,
    input  logic               mid_l,
    input  logic               mid_r,
    output logic               above_bit,
    output logic               mid_bit,
    output logic               next_upper,
    output logic               next_lower
);

    logic                      above_reg;
    logic                      above_next;
    logic                      mid_reg;
    logic                      mid_next;
    logic [lrg_pkg::CNT_W-1:0] n_upper;
    logic [lrg_pkg::CNT_W-1:0] n_lower;

    function automatic logic rule_fires(
        input logic                      alive,
        input logic [lrg_pkg::CNT_W-1:0] n,
        input lrg_pkg::rules_t           r
    );
        logic fire;
        if (alive)
        begin
            fire = (n >= r.survive_min) && (n <= r.survive_max);
        end
        else
        begin
            fire = (n >= r.birth_min) && (n <= r.birth_max);
        end
        return fire;
    endfunction

    // Count neighbors of the middle row (row below is the incoming row)
    assign n_upper = lrg_pkg::CNT_W'(above_l) + lrg_pkg::CNT_W'(above_reg)
                   + lrg_pkg::CNT_W'(above_r) + lrg_pkg::CNT_W'(mid_l)
                   + lrg_pkg::CNT_W'(mid_r)   + lrg_pkg::CNT_W'(row_l)
                   + lrg_pkg::CNT_W'(row_c)   + lrg_pkg::CNT_W'(row_r);

    // Count neighbors of the incoming row with a dead row below it
    assign n_lower = lrg_pkg::CNT_W'(mid_l) + lrg_pkg::CNT_W'(mid_reg)
                   + lrg_pkg::CNT_W'(mid_r) + lrg_pkg::CNT_W'(row_l)
                   + lrg_pkg::CNT_W'(row_r);

    assign next_upper = rule_fires(mid_reg, n_upper, rules);
    assign next_lower = rule_fires(row_c, n_lower, rules);

    // Shift the column down one row, drop it at the bottom of a frame
    always_comb
    begin
        above_next = above_reg;
        mid_next   = mid_reg;
        if (ctrl.advance)
        begin
            above_next = ctrl.flush ? 1'b0 : mid_reg;
            mid_next   = ctrl.flush ? 1'b0 : row_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg <= 1'b0;
            mid_reg   <= 1'b0;
        end
        else
        begin
            above_reg <= above_next;
            mid_reg   <= mid_next;
        end
    end

    assign above_bit = above_reg;
    assign mid_bit   = mid_reg;

endmodule

// File: design/lrg_out_queue.sv
// Small result queue: takes up to two beats per cycle, sends one per cycle unless stalled.
// Depends on lrg_pkg for the beat struct, push struct and depth.
`timescale 1ns / 1ps

module lrg_out_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  lrg_pkg::push_t      push,
    input  lrg_pkg::gen_beat_t  first_beat,
    input  lrg_pkg::gen_beat_t  second_beat,
    output logic                almost_full,
    output logic                gen_valid,
    input  logic                gen_stall,
    output lrg_pkg::gen_beat_t  gen_beat
);

    localparam int DEPTH = lrg_pkg::OUT_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lrg_pkg::gen_beat_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   head_next;
    logic [PTR_W-1:0]   tail_reg;
    logic [PTR_W-1:0]   tail_next;
    logic [PTR_W-1:0]   tail_plus;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    assign pop       = gen_valid && !gen_stall;
    assign tail_plus = tail_reg + PTR_W'(1);

    // Advance pointers and occupancy
    always_comb
    begin
        head_next  = pop ? head_reg + PTR_W'(1) : head_reg;
        tail_next  = tail_reg + PTR_W'(push.first) + PTR_W'(push.second);
        count_next = count_reg + CNT_W'(push.first) + CNT_W'(push.second)
                   - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Write the pushed beats at the tail
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (push.first && (tail_reg == PTR_W'(i)))
            begin
                entry_reg[i] <= first_beat;
            end
            if (push.second && (tail_plus == PTR_W'(i)))
            begin
                entry_reg[i] <= second_beat;
            end
        end
    end

    // Hold room for two beats so a bottom row never overflows
    assign almost_full = count_reg > CNT_W'(DEPTH - 2);
    assign gen_valid   = count_reg != '0;
    assign gen_beat    = entry_reg[head_reg];

endmodule

// File: design/life_row_generation_step.sv
// A result beat is written into the result queue as the row beat completing it is accepted.
// Throughput: one row beat per cycle while not stalled; a bottom row of an open frame queues two.
// Rows are taken while the four-entry result queue has room for two beats.
// Rate is set by the column cell row, which evaluates every column at once.
// Reset: rule registers go to 2, 3, 3, 3, row history clears, queue empties.
// Uses lrg_pkg, lrg_cell and lrg_out_queue.
`timescale 1ns / 1ps

module life_row_generation_step
#(
    parameter int COLS = lrg_pkg::COLS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              row_valid,
    output logic                              row_stall,
    input  lrg_pkg::row_beat_t                row_beat,
    output logic                              gen_valid,
    input  logic                              gen_stall,
    output lrg_pkg::gen_beat_t                gen_beat,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    lrg_pkg::rules_t     rules_reg;
    lrg_pkg::rules_t     rules_next;
    logic                open_reg;
    logic                open_next;
    logic                accept;
    logic                almost_full;
    lrg_pkg::cell_ctrl_t ctrl;
    lrg_pkg::push_t      push;
    lrg_pkg::gen_beat_t  upper_beat;
    lrg_pkg::gen_beat_t  lower_beat;
    lrg_pkg::gen_beat_t  first_beat;

    logic [COLS-1:0]     above_vec;
    logic [COLS-1:0]     mid_vec;
    logic [COLS-1:0]     upper_vec;
    logic [COLS-1:0]     lower_vec;
    logic [COLS+1:0]     row_pad;
    logic [COLS+1:0]     above_pad;
    logic [COLS+1:0]     mid_pad;

    // Rule registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        rules_next = rules_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lrg_pkg::REG_SURVIVE_MIN: rules_next.survive_min = cfg_data;
                lrg_pkg::REG_SURVIVE_MAX: rules_next.survive_max = cfg_data;
                lrg_pkg::REG_BIRTH_MIN:   rules_next.birth_min   = cfg_data;
                lrg_pkg::REG_BIRTH_MAX:   rules_next.birth_max   = cfg_data;
                default:                  rules_next = rules_reg;
            endcase
        end
    end

    // Track whether a frame is in progress
    assign row_stall = almost_full;
    assign accept    = row_valid && !row_stall;
    assign open_next = accept ? !row_beat.frame_end : open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rules_reg.survive_min <= lrg_pkg::SURVIVE_MIN_RST;
            rules_reg.survive_max <= lrg_pkg::SURVIVE_MAX_RST;
            rules_reg.birth_min   <= lrg_pkg::BIRTH_MIN_RST;
            rules_reg.birth_max   <= lrg_pkg::BIRTH_MAX_RST;
            open_reg              <= 1'b0;
        end
        else
        begin
            rules_reg <= rules_next;
            open_reg  <= open_next;
        end
    end

    assign ctrl.advance = accept;
    assign ctrl.flush   = row_beat.frame_end;

    // Pad the rows with dead cells past both edges
    assign row_pad   = {1'b0, row_beat.row_cells[COLS-1:0], 1'b0};
    assign above_pad = {1'b0, above_vec, 1'b0};
    assign mid_pad   = {1'b0, mid_vec, 1'b0};

    // Column cell row
    for (genvar c = 0; c < COLS; c++)
    begin : g_cell
        lrg_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .rules      (rules_reg),
            .row_l      (row_pad[c]),
            .row_c      (row_pad[c+1]),
            .row_r      (row_pad[c+2]),
            .above_l    (above_pad[c]),
            .above_r    (above_pad[c+2]),
            .mid_l      (mid_pad[c]),
            .mid_r      (mid_pad[c+2]),
            .above_bit  (above_vec[c]),
            .mid_bit    (mid_vec[c]),
            .next_upper (upper_vec[c]),
            .next_lower (lower_vec[c])
        );
    end

    // Form result beats; columns past the grid stay zero
    assign upper_beat.next_cells = lrg_pkg::ROW_W'(upper_vec);
    assign upper_beat.final_row  = 1'b0;
    assign lower_beat.next_cells = lrg_pkg::ROW_W'(lower_vec);
    assign lower_beat.final_row  = 1'b1;

    // Middle row result first, then the bottom row result
    assign first_beat  = open_reg ? upper_beat : lower_beat;
    assign push.first  = accept && (open_reg || row_beat.frame_end);
    assign push.second = accept && open_reg && row_beat.frame_end;

    lrg_out_queue u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .first_beat  (first_beat),
        .second_beat (lower_beat),
        .almost_full (almost_full),
        .gen_valid   (gen_valid),
        .gen_stall   (gen_stall),
        .gen_beat    (gen_beat)
    );

endmodule

// File: design/lrg_checker.sv
// Port-level checks for life_row_generation_step, attached by bind.
// Depends on lrg_pkg for the beat structs and port widths.
`timescale 1ns / 1ps

module lrg_checker
#(
    parameter int COLS = lrg_pkg::COLS_DEFAULT
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           row_valid,
    input logic                           row_stall,
    input lrg_pkg::row_beat_t             row_beat,
    input logic                           gen_valid,
    input logic                           gen_stall,
    input lrg_pkg::gen_beat_t             gen_beat,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);

    // Hold a stalled result beat
    a_gen_hold: assert property (@(posedge clk) disable iff (!rst_n)
        gen_valid && gen_stall |=> gen_valid && $stable(gen_beat))
        else $error("result beat changed while stalled");

    // Keep columns past the grid dead
    a_cols_zero: assert property (@(posedge clk) disable iff (!rst_n)
        gen_valid |-> (gen_beat.next_cells >> COLS) == '0)
        else $error("live cell beyond grid width");

    // A bottom row always yields a result beat next cycle
    a_bottom_result: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_stall && row_beat.frame_end |=> gen_valid)
        else $error("bottom row gave no result");

    // Never stall rows while no result is pending
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !gen_valid |-> !row_stall)
        else $error("row stalled with empty result queue");

    // Take every register write at once
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write held off");

endmodule

bind life_row_generation_step lrg_checker #(.COLS(COLS)) u_lrg_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .row_valid (row_valid),
    .row_stall (row_stall),
    .row_beat  (row_beat),
    .gen_valid (gen_valid),
    .gen_stall (gen_stall),
    .gen_beat  (gen_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
